@@ design/nsm_pkg.sv @@
// ----------------------------------------------------------------------------
// nsm_pkg: shared types and constants of the NFA symbol matcher
// Sizes of the automaton, field widths, opcode and sequencer codes, and the
// layout of one stored transition.
// ----------------------------------------------------------------------------
package nsm_pkg;

    // Automaton size
    localparam int MAX_STATES      = 16;
    localparam int SLOTS_PER_STATE = 8;

    // Derived widths
    localparam int STATE_W   = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int SLOT_W    = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
    localparam int SLOT_CNT_W = $clog2(SLOTS_PER_STATE + 1);
    localparam int NUM_W     = $clog2(MAX_STATES + 1);

    // Fixed field widths of the channels
    localparam int OPC_W     = 2;
    localparam int FROM_W    = 4;
    localparam int SLOT_IN_W = 3;
    localparam int SYM_W     = 8;
    localparam int TGT_W     = 4;
    localparam int ACT_W     = 16;
    localparam int SEEN_W    = 16;
    localparam int CFG_W     = 5;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // Item opcodes
    typedef enum logic [OPC_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_START = 2'd2,
        OP_FEED  = 2'd3
    } opcode_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FEED,
        ST_DONE
    } seq_state_t;

    // One stored transition (its valid bit lives in flip-flops)
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [TGT_W-1:0] target;
    } entry_t;

    // Result of evaluating one slot row against the active set
    typedef struct packed {
        logic [MAX_STATES-1:0] next_bits;
        logic                  fired;
    } fire_res_t;

endpackage

@@ design/nsm_cmd_if.sv @@
// ----------------------------------------------------------------------------
// nsm_cmd_if: command channel of the NFA symbol matcher
// Carries one command item: opcode and the fields of a load or feed.
// ----------------------------------------------------------------------------
interface nsm_cmd_if;
    import nsm_pkg::*;

    logic                 valid;
    logic                 ready;
    opcode_t              opcode;
    logic [FROM_W-1:0]    from_state;
    logic [SLOT_IN_W-1:0] slot;
    logic [SYM_W-1:0]     symbol;
    logic [TGT_W-1:0]     to_state;

    modport source (output valid, opcode, from_state, slot, symbol, to_state,
                    input ready);
    modport sink   (input valid, opcode, from_state, slot, symbol, to_state,
                    output ready);
endinterface

@@ design/nsm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// nsm_rsp_if: result channel of the NFA symbol matcher
// Carries one result item per command: active set, moved, accepted, count.
// ----------------------------------------------------------------------------
interface nsm_rsp_if;
    import nsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  active_states;
    logic              moved;
    logic              accepted;
    logic [SEEN_W-1:0] symbols_seen;

    modport source (output valid, active_states, moved, accepted, symbols_seen,
                    input ready);
    modport sink   (input valid, active_states, moved, accepted, symbols_seen,
                    output ready);
endinterface

@@ design/nsm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// nsm_cfg_if: configuration write channel of the NFA symbol matcher
// Carries the write data of the states_in_use register.
// ----------------------------------------------------------------------------
interface nsm_cfg_if;
    import nsm_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ design/nsm_ram.sv @@
// ----------------------------------------------------------------------------
// nsm_ram: generic single-port-write RAM with registered read
// One write address and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module nsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ design/nsm_fire.sv @@
// ----------------------------------------------------------------------------
// nsm_fire: slot-row evaluation unit
// Checks one transition slot of every state at once against the fed symbol
// and returns the targets reached and whether any transition fired.
// ----------------------------------------------------------------------------
module nsm_fire (
    input  nsm_pkg::entry_t                   row [nsm_pkg::MAX_STATES],
    input  logic [nsm_pkg::MAX_STATES-1:0]    row_valid,
    input  logic [nsm_pkg::MAX_STATES-1:0]    sources,
    input  logic [nsm_pkg::SYM_W-1:0]         symbol,
    input  logic [nsm_pkg::NUM_W-1:0]         num_states,
    output nsm_pkg::fire_res_t                res
);
    import nsm_pkg::*;

    logic [MAX_STATES-1:0] hit;

    // A slot fires when its source is active, it is valid and the symbol matches.
    always_comb
    begin
        for (int s = 0; s < MAX_STATES; s++)
        begin
            hit[s] = sources[s] && row_valid[s] && (row[s].symbol == symbol);
        end
    end

    // Decode each fired target; targets out of use add nothing.
    always_comb
    begin
        res.next_bits = '0;
        res.fired     = |hit;
        for (int s = 0; s < MAX_STATES; s++)
        begin
            if (hit[s] && (NUM_W'(row[s].target) < num_states)
                       && (int'(row[s].target) < MAX_STATES))
            begin
                res.next_bits[STATE_W'(row[s].target)] = 1'b1;
            end
        end
    end

endmodule

@@ design/nfa_symbol_matcher_top.sv @@
// ----------------------------------------------------------------------------
// nfa_symbol_matcher_top: nondeterministic finite automaton simulator
// Steps an NFA over a byte string; the transition table is loaded by items.
// ----------------------------------------------------------------------------
// One command item is taken at a time and yields one result item. Load, clear
// and start items pass through the execute and done states before the next
// acceptance. A feed item walks the slots: the table is held as one
// RAM per state, all read at the same slot address, so one slot of every
// state is checked per cycle, and the slots are walked in turn. The result
// is held in an output register, so a new command is taken while the
// previous result still waits. Valid bits of the table sit in flip-flops and
// are cleared at once by reset and by a clear item; states_in_use may be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module nfa_symbol_matcher_top (
    input logic      clk,
    input logic      rst_n,
    nsm_cmd_if.sink  cmd,
    nsm_rsp_if.source rsp,
    nsm_cfg_if.sink  cfg
);
    import nsm_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    seq_state_t state_reg, state_next;

    opcode_t              op_reg,   op_next;
    logic [FROM_W-1:0]    from_reg, from_next;
    logic [SLOT_IN_W-1:0] slot_reg, slot_next;
    logic [SYM_W-1:0]     sym_reg,  sym_next;
    logic [TGT_W-1:0]     to_reg,   to_next;

    logic [CFG_W-1:0]      states_cfg_reg;
    logic [MAX_STATES-1:0] active_reg, active_next;
    logic [SEEN_W-1:0]     count_reg, count_next;
    logic                  moved_reg, moved_next;

    logic [MAX_STATES-1:0] valid_reg [SLOTS_PER_STATE];
    logic [MAX_STATES-1:0] valid_next [SLOTS_PER_STATE];
    logic [MAX_STATES-1:0] vrow_reg, vrow_next;

    logic [SLOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [MAX_STATES-1:0] acc_reg, acc_next;
    logic                  fired_reg, fired_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [ACT_W-1:0]      rsp_act_reg, rsp_act_next;
    logic                  rsp_moved_reg, rsp_moved_next;
    logic                  rsp_acc_reg, rsp_acc_next;
    logic [SEEN_W-1:0]     rsp_seen_reg, rsp_seen_next;

    // ------------------------------------------------------------------
    // Effective number of states in use and its mask
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]      num_states;
    logic [MAX_STATES-1:0] state_mask;
    logic [MAX_STATES-1:0] active_masked;

    always_comb
    begin
        if (states_cfg_reg == '0)
        begin
            num_states = NUM_W'(1);
        end
        else if (int'(states_cfg_reg) > MAX_STATES)
        begin
            num_states = NUM_W'(MAX_STATES);
        end
        else
        begin
            num_states = NUM_W'(states_cfg_reg);
        end
        for (int s = 0; s < MAX_STATES; s++)
        begin
            state_mask[s] = (s < int'(num_states));
        end
    end

    assign active_masked = active_reg & state_mask;

    // ------------------------------------------------------------------
    // Transition storage: one RAM per source state, addressed by slot
    // ------------------------------------------------------------------
    logic                  load_ok;
    logic [SLOT_W-1:0]     rd_addr;
    logic [SLOT_W-1:0]     wr_addr;
    entry_t                wr_entry;
    entry_t                row_data [MAX_STATES];
    logic [MAX_STATES-1:0] ram_we;

    assign load_ok  = (int'(from_reg) < MAX_STATES) && (int'(slot_reg) < SLOTS_PER_STATE);
    assign rd_addr  = cnt_reg[SLOT_W-1:0];
    assign wr_addr  = SLOT_W'(slot_reg);
    assign wr_entry = '{symbol: sym_reg, target: to_reg};

    for (genvar s = 0; s < MAX_STATES; s++)
    begin : g_state_ram
        assign ram_we[s] = (state_reg == ST_EXEC) && (op_reg == OP_LOAD) && load_ok
                           && (int'(from_reg) == s);

        nsm_ram #(
            .WIDTH ($bits(entry_t)),
            .DEPTH (SLOTS_PER_STATE)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[s]),
            .waddr (wr_addr),
            .wdata (wr_entry),
            .raddr (rd_addr),
            .rdata (row_data[s])
        );
    end

    // ------------------------------------------------------------------
    // Shared slot-row evaluation unit
    // ------------------------------------------------------------------
    fire_res_t fire;

    nsm_fire u_fire (
        .row        (row_data),
        .row_valid  (vrow_reg),
        .sources    (active_masked),
        .symbol     (sym_reg),
        .num_states (num_states),
        .res        (fire)
    );

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic cmd_take;
    logic rsp_free;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.active_states = rsp_act_reg;
    assign rsp.moved         = rsp_moved_reg;
    assign rsp.accepted      = rsp_acc_reg;
    assign rsp.symbols_seen  = rsp_seen_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        from_next      = from_reg;
        slot_next      = slot_reg;
        sym_next       = sym_reg;
        to_next        = to_reg;
        active_next    = active_reg;
        count_next     = count_reg;
        moved_next     = moved_reg;
        valid_next     = valid_reg;
        vrow_next      = valid_reg[rd_addr];
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        acc_next       = acc_reg;
        fired_next     = fired_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_act_next   = rsp_act_reg;
        rsp_moved_next = rsp_moved_reg;
        rsp_acc_next   = rsp_acc_reg;
        rsp_seen_next  = rsp_seen_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    op_next    = cmd.opcode;
                    from_next  = cmd.from_state;
                    slot_next  = cmd.slot;
                    sym_next   = cmd.symbol;
                    to_next    = cmd.to_state;
                    cnt_next   = '0;
                    acc_next   = '0;
                    fired_next = 1'b0;
                    state_next = (cmd.opcode == OP_FEED) ? ST_FEED : ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        if (load_ok)
                        begin
                            valid_next[wr_addr][STATE_W'(from_reg)] = 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        for (int k = 0; k < SLOTS_PER_STATE; k++)
                        begin
                            valid_next[k] = '0;
                        end
                    end
                    OP_START:
                    begin
                        active_next = MAX_STATES'(1);
                        count_next  = '0;
                        moved_next  = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_DONE;
            end

            ST_FEED:
            begin
                // Issue one slot read per cycle; evaluate it the cycle after.
                if (int'(cnt_reg) < SLOTS_PER_STATE)
                begin
                    cnt_next  = cnt_reg + SLOT_CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    acc_next   = acc_reg | fire.next_bits;
                    fired_next = fired_reg | fire.fired;
                end
                else if (int'(cnt_reg) == SLOTS_PER_STATE)
                begin
                    active_next = acc_reg;
                    moved_next  = fired_reg;
                    if (count_reg != SEEN_MAX)
                    begin
                        count_next = count_reg + SEEN_W'(1);
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Drop states out of use and post the result.
                if (rsp_free)
                begin
                    active_next    = active_masked;
                    rsp_valid_next = 1'b1;
                    rsp_act_next   = ACT_W'(active_masked);
                    rsp_moved_next = moved_reg;
                    rsp_acc_next   = active_masked[STATE_W'(num_states - NUM_W'(1))];
                    rsp_seen_next  = count_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            states_cfg_reg <= CFG_W'(1);
            active_reg     <= MAX_STATES'(1);
            count_reg      <= '0;
            moved_reg      <= 1'b1;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            for (int k = 0; k < SLOTS_PER_STATE; k++)
            begin
                valid_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            moved_reg     <= moved_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            valid_reg     <= valid_next;
            if (cfg.valid && cfg.ready)
            begin
                states_cfg_reg <= cfg.data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        from_reg      <= from_next;
        slot_reg      <= slot_next;
        sym_reg       <= sym_next;
        to_reg        <= to_next;
        vrow_reg      <= vrow_next;
        acc_reg       <= acc_next;
        fired_reg     <= fired_next;
        rsp_act_reg   <= rsp_act_next;
        rsp_moved_reg <= rsp_moved_next;
        rsp_acc_reg   <= rsp_acc_next;
        rsp_seen_reg  <= rsp_seen_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // The block is not ready in the cycle after it takes a command.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !cmd.ready)
        else $error("command accepted while previous one in progress");

    // The slot walk never runs past the last slot.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= SLOTS_PER_STATE)
        else $error("slot counter out of range");

    // A pending slot evaluation only exists during a feed.
    a_pend_in_feed: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_FEED))
        else $error("slot evaluation outside feed");

    // After a result is posted, no state out of use remains active.
    a_active_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && rsp_free) |=> ((active_reg & ~$past(state_mask)) == '0))
        else $error("active state beyond states in use");

    // A finished command posts its result and returns to idle.
    a_rsp_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && rsp_free) |=> (rsp_valid_reg && state_reg == ST_IDLE))
        else $error("result not posted on completion");
`endif

endmodule
